### src/qpst_pkg.sv
`default_nettype none

package qpst_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 1024;
  localparam int unsigned CFG_W = 11;
  localparam int unsigned ID_W = 10;
  localparam logic [CFG_W-1:0] QUEUE_SIZE_RESET = 11'd1024;

  typedef enum logic [1:0] {
    ACT_ALLOC    = 2'd0,
    ACT_COMPLETE = 2'd1,
    ACT_QUERY    = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    SLOT_PENDING = 2'd0,
    SLOT_DONE    = 2'd1,
    SLOT_NEVER   = 2'd2
  } slot_e;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_BUSY     = 3'd1,
    ST_CONSUMED = 3'd2,
    ST_NO_NEW   = 3'd3,
    ST_ANSWERED = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]      action;
    logic            entry_phase;
    logic [ID_W-1:0] entry_command_id;
    logic [ID_W-1:0] query_command_id;
  } qpst_req_t;

  typedef struct packed {
    status_e         status;
    logic [ID_W-1:0] granted_slot;
    logic [ID_W-1:0] submit_doorbell_value;
    logic            submit_doorbell_write;
    logic [ID_W-1:0] complete_doorbell_value;
    logic            complete_doorbell_write;
    logic            is_done;
  } qpst_rsp_t;

endpackage

`default_nettype wire

### src/qpst_slot_table.sv
`default_nettype none

module qpst_slot_table import qpst_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(QUEUE_DEPTH_DEFAULT)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  output logic               ready_o,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output slot_e              rd_data_o,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire slot_e         wr_data_i
);

  slot_e         mem [DEPTH];
  slot_e         rd_q;
  logic          byp_q;
  slot_e         byp_data_q;
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  logic          we;
  logic [AW-1:0] waddr;
  slot_e         wdata;

  // clearing pass owns the write port right after reset
  always_comb begin
    if (clr_busy_q) begin
      we    = 1'b1;
      waddr = clr_addr_q;
      wdata = SLOT_NEVER;
    end else begin
      we    = wr_en_i;
      waddr = wr_addr_i;
      wdata = wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // same-edge write to the address being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= we && (waddr == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      byp_data_q <= wdata;
    end
  end

  assign ready_o   = !clr_busy_q;
  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

`default_nettype wire

### src/queue_pair_slot_tracker_top.sv
`default_nettype none

// channel   valid / ready              payload
// req       req_valid_i / req_ready_o  req_i (qpst_req_t)
// rsp       rsp_valid_o / rsp_ready_i  rsp_o (qpst_rsp_t)
// cfg       cfg_valid_i / cfg_ready_o  cfg_queue_size_i
//
// One request per cycle while req_ready_o is high. An accepted request is registered in s1
// with the registered output of the single slot table read port, then its response in rsp_q.
// After reset a clearing pass writes SLOT_NEVER to every slot before req_ready_o rises.
// A stalled response holds the stage behind it, and then the request input.

module queue_pair_slot_tracker_top import qpst_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  input  wire qpst_req_t        req_i,
  output logic                  rsp_valid_o,
  input  wire logic             rsp_ready_i,
  output qpst_rsp_t             rsp_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_queue_size_i
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned DW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CW = (DW > CFG_W) ? DW : CFG_W;
  localparam logic [CW-1:0] DepthC   = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] MinSizeC = CW'(2);

  logic [CFG_W-1:0] queue_size_q;
  logic             s1_v_q;
  qpst_req_t        s1_q;
  logic [AW-1:0]    tail_q, tail_d;
  logic [AW-1:0]    head_q, head_d;
  logic             phase_q, phase_d;
  logic             batch_q, batch_d;
  logic             rsp_v_q;
  qpst_rsp_t        rsp_q, rsp_d;

  logic             req_go, s1_go, tbl_ready, grant;
  logic [CW-1:0]    qs, size, nt_w, nh_w;
  logic [AW-1:0]    nt, nh, rd_addr, wr_addr;
  logic             wr_en;
  slot_e            wr_data, slot_rd;

  assign cfg_ready_o = 1'b1;
  assign s1_go       = s1_v_q && (!rsp_v_q || rsp_ready_i);
  assign req_ready_o = tbl_ready && (!s1_v_q || s1_go);
  assign req_go      = req_valid_i && req_ready_o;

  assign qs   = CW'(queue_size_q);
  assign size = (qs < MinSizeC) ? MinSizeC : ((qs > DepthC) ? DepthC : qs);
  assign nt_w = CW'(tail_q) + CW'(1);
  assign nh_w = CW'(head_q) + CW'(1);
  assign nt   = (nt_w >= size) ? '0 : nt_w[AW-1:0];
  assign nh   = (nh_w >= size) ? '0 : nh_w[AW-1:0];

  always_comb begin
    tail_d  = tail_q;
    head_d  = head_q;
    phase_d = phase_q;
    batch_d = batch_q;
    rsp_d   = '0;
    grant   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = tail_q;
    wr_data = SLOT_PENDING;
    if (s1_q.action == ACT_ALLOC) begin
      if (slot_rd == SLOT_PENDING) begin
        rsp_d.status = ST_BUSY;
      end else begin
        grant                       = 1'b1;
        rsp_d.status                = ST_GRANTED;
        rsp_d.granted_slot          = ID_W'(tail_q);
        rsp_d.submit_doorbell_value = ID_W'(nt);
        rsp_d.submit_doorbell_write = 1'b1;
        wr_en                       = s1_go;
        tail_d                      = s1_go ? nt : tail_q;
      end
    end else if (s1_q.action == ACT_COMPLETE) begin
      if (s1_q.entry_phase == phase_q) begin
        rsp_d.status = ST_CONSUMED;
        wr_addr      = AW'(s1_q.entry_command_id);
        wr_data      = SLOT_DONE;
        wr_en        = s1_go && (int'(s1_q.entry_command_id) < int'(QUEUE_DEPTH));
        if (s1_go) begin
          head_d  = nh;
          phase_d = (nh_w >= size) ? !phase_q : phase_q;
          batch_d = 1'b1;
        end
      end else begin
        rsp_d.status = ST_NO_NEW;
        if (batch_q) begin
          rsp_d.complete_doorbell_value = ID_W'(head_q);
          rsp_d.complete_doorbell_write = 1'b1;
          batch_d                       = s1_go ? 1'b0 : batch_q;
        end
      end
    end else begin
      rsp_d.status  = ST_ANSWERED;
      rsp_d.is_done = (int'(s1_q.query_command_id) < int'(QUEUE_DEPTH))
                      && (slot_rd == SLOT_DONE);
    end
  end

  assign rd_addr = ((req_i.action == ACT_ALLOC) || (req_i.action == ACT_COMPLETE))
                   ? tail_d : AW'(req_i.query_command_id);

  qpst_slot_table #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_slot_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ready_o   (tbl_ready),
    .rd_en_i   (req_go),
    .rd_addr_i (rd_addr),
    .rd_data_o (slot_rd),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_size_q <= QUEUE_SIZE_RESET;
      tail_q       <= '0;
      head_q       <= '0;
      phase_q      <= 1'b1;
      batch_q      <= 1'b0;
      s1_v_q       <= 1'b0;
      rsp_v_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        queue_size_q <= cfg_queue_size_i;
      end
      tail_q  <= tail_d;
      head_q  <= head_d;
      phase_q <= phase_d;
      batch_q <= batch_d;
      if (req_go) begin
        s1_v_q <= 1'b1;
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
      if (s1_go) begin
        rsp_v_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_go) begin
      s1_q <= req_i;
    end
    if (s1_go) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  a_grant_moves_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && grant) |=> (tail_q != $past(tail_q)))
    else $error("granted allocate left the tail in place");

  a_phase_flip_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && (phase_d != phase_q)) |=> (head_q == '0))
    else $error("expected phase toggled without head wrap");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tbl_ready |=> !s1_v_q || $past(s1_v_q))
    else $error("request accepted during slot table clear");

  a_doorbell_on_no_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && rsp_d.complete_doorbell_write) |=> !batch_q)
    else $error("batch not closed after completion doorbell");
`endif

endmodule

`default_nettype wire
